@@ sv/great_circle_distance_assert.svh @@
// ----------------------------------------------------------------------------
// Great circle distance assertion macros
// Concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// checked only outside reset
`define GCD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define GCD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Great circle distance package
// Shared types, fixed-point constants and table functions.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam logic [63:0] QONE         = 64'h1000_0000_0000_0000;
   localparam logic [63:0] PI_Q60       = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] RAD_DIV      = 64'd3600000000;
   localparam logic [63:0] RAD_QUO      = PI_Q60 / RAD_DIV;
   localparam logic [63:0] RAD_REM      = PI_Q60 % RAD_DIV;
   localparam logic [95:0] RAD_FRAC_W   = {RAD_REM, 32'b0} / {32'b0, RAD_DIV};
   localparam logic [31:0] RAD_FRAC     = RAD_FRAC_W[31:0];
   localparam logic [63:0] GAIN_SEED    = (QONE / 64'd10) * 64'd6;
   localparam logic [31:0] DIV6_MAGIC   = 32'hAAAA_AAAB;
   localparam logic [63:0] DIAMETER_MM  = 64'd12742000000;
   localparam logic [63:0] HALF_CIRC_MM = 64'd20015086796;
   localparam logic [121:0] H_ONE       = 122'(1) << 120;
   localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
   localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
   localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
   localparam int SQRT_BITS = 61;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_type;

   typedef struct packed {
      logic [121:0] rem;
      logic [60:0]  root;
   } sqrt_type;

   function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] odd_div(logic [63:0] x, int k);
      logic [63:0] q;
      case (k)
         0: q = x;
         1: q = x / 64'd3;
         2: q = x / 64'd5;
         3: q = x / 64'd7;
         4: q = x / 64'd9;
         5: q = x / 64'd11;
         6: q = x / 64'd13;
         7: q = x / 64'd15;
         8: q = x / 64'd17;
         9: q = x / 64'd19;
         10: q = x / 64'd21;
         11: q = x / 64'd23;
         12: q = x / 64'd25;
         13: q = x / 64'd27;
         14: q = x / 64'd29;
         15: q = x / 64'd31;
         16: q = x / 64'd33;
         17: q = x / 64'd35;
         18: q = x / 64'd37;
         19: q = x / 64'd39;
         20: q = x / 64'd41;
         21: q = x / 64'd43;
         22: q = x / 64'd45;
         23: q = x / 64'd47;
         24: q = x / 64'd49;
         25: q = x / 64'd51;
         26: q = x / 64'd53;
         27: q = x / 64'd55;
         28: q = x / 64'd57;
         29: q = x / 64'd59;
         30: q = x / 64'd61;
         31: q = x / 64'd63;
         default: q = '0;
      endcase
      return q;
   endfunction

   // arctan(2^-i) in Q60, series evaluated in Q63
   function automatic logic [63:0] atan_entry(int i);
      logic [63:0] acc;
      logic [63:0] t;
      acc = '0;
      if (i == 0) begin
         acc = PI_Q60 >> 2;
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) < 64) begin
               t = odd_div(64'h8000_0000_0000_0000 >> (i * (2 * k + 1)), k);
               acc = (k % 2 == 1) ? acc - t : acc + t;
            end
         end
         acc = (acc + 64'd4) >> 3;
      end
      return acc;
   endfunction

   // 1/K for n stages, Newton iteration on 1/sqrt(prod(1 + 4^-i))
   function automatic logic [63:0] inv_gain(int n);
      logic [63:0] g;
      logic [63:0] r;
      g = QONE;
      r = GAIN_SEED;
      for (int i = 0; i < n; i++) begin
         if (2 * i < 64) begin
            g = g + (g >> (2 * i));
         end
      end
      for (int j = 0; j < 8; j++) begin
         r = mulq(r, 64'd3 * QONE - mulq(g, mulq(r, r))) >> 1;
      end
      return r;
   endfunction

endpackage

@@ sv/gcd_mul.sv @@
// ----------------------------------------------------------------------------
// Signed 64x64 multiplier
// Two stages: 32-bit partial products, then sum. Gives the full magnitude
// product and the Q60 product truncated toward zero.
// ----------------------------------------------------------------------------
module gcd_mul (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] mul_a,
   input  logic signed [63:0] mul_b,
   output logic signed [63:0] prod_q60,
   output logic [127:0]       prod_full
);

   logic [63:0]  mag_a;
   logic [63:0]  mag_b;
   logic         neg_ff;
   logic [63:0]  ll_ff;
   logic [63:0]  lh_ff;
   logic [63:0]  hl_ff;
   logic [63:0]  hh_ff;
   logic [127:0] sum;
   logic [63:0]  q_mag;
   logic [63:0]  q_in;
   logic [127:0] full_ff;
   logic [63:0]  q_ff;

   always_comb begin
      mag_a = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
      mag_b = mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
      sum   = {hh_ff, 64'b0} + ({64'b0, lh_ff} << 32) + ({64'b0, hl_ff} << 32)
            + {64'b0, ll_ff};
      q_mag = sum[123:60];
      q_in  = neg_ff ? 64'(-q_mag) : q_mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= mul_a[63] ^ mul_b[63];
         ll_ff   <= {32'b0, mag_a[31:0]} * {32'b0, mag_b[31:0]};
         lh_ff   <= {32'b0, mag_a[31:0]} * {32'b0, mag_b[63:32]};
         hl_ff   <= {32'b0, mag_a[63:32]} * {32'b0, mag_b[31:0]};
         hh_ff   <= {32'b0, mag_a[63:32]} * {32'b0, mag_b[63:32]};
         full_ff <= sum;
         q_ff    <= q_in;
      end
   end

   assign prod_full = full_ff;
   assign prod_q60  = signed'(q_ff);

endmodule

@@ sv/gcd_to_rad.sv @@
// ----------------------------------------------------------------------------
// Angle converter
// Signed 1e-7 degree half-angle units to Q60 radians, rounded to nearest,
// via reciprocal multiply and one remainder correction. Four stages.
// ----------------------------------------------------------------------------
module gcd_to_rad (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] units,
   output logic signed [63:0] radians
);

   logic [30:0] mag;
   logic [63:0] rnd_sum;
   logic [63:0] rem;
   logic [31:0] q_fix;
   logic [63:0] v;

   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [62:0] mf_ff;
   logic [62:0] mr_ff;
   logic [63:0] mq1_ff, mq2_ff, mq3_ff;
   logic [31:0] q0_ff, q0b_ff;
   logic [63:0] n_ff, n3_ff;
   logic [63:0] qd_ff;
   logic [63:0] rad_ff;

   always_comb begin
      mag     = units[31] ? 31'(-units) : units[30:0];
      rnd_sum = {1'b0, mf_ff} + 64'h8000_0000;
      rem     = n3_ff - qd_ff;
      q_fix   = q0b_ff + ((rem >= gcd_pkg::RAD_DIV) ? 32'd1 : 32'd0);
      v       = mq3_ff + {32'b0, q_fix};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= units[31];
         mf_ff   <= {32'b0, mag} * {31'b0, gcd_pkg::RAD_FRAC};
         mr_ff   <= {32'b0, mag} * {31'b0, gcd_pkg::RAD_REM[31:0]};
         mq1_ff  <= {33'b0, mag} * gcd_pkg::RAD_QUO;
         neg2_ff <= neg1_ff;
         q0_ff   <= rnd_sum[63:32];
         n_ff    <= {1'b0, mr_ff} + (gcd_pkg::RAD_DIV >> 1);
         mq2_ff  <= mq1_ff;
         neg3_ff <= neg2_ff;
         qd_ff   <= {32'b0, q0_ff} * {32'b0, gcd_pkg::RAD_DIV[31:0]};
         q0b_ff  <= q0_ff;
         n3_ff   <= n_ff;
         mq3_ff  <= mq2_ff;
         rad_ff  <= neg3_ff ? 64'(-v) : v;
      end
   end

   assign radians = signed'(rad_ff);

endmodule

@@ sv/gcd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation with a fixed shift, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
   parameter int STAGE     = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic                 clock,
   input  logic                 en,
   input  gcd_pkg::cordic_type  cell_in,
   output gcd_pkg::cordic_type  cell_out
);

   localparam logic signed [63:0] ATN = signed'(gcd_pkg::atan_entry(STAGE));

   logic                signed [63:0] dx;
   logic                signed [63:0] dy;
   logic                down;
   gcd_pkg::cordic_type step_in;
   gcd_pkg::cordic_type step_ff;

   always_comb begin
      dx   = cell_in.y >>> STAGE;
      dy   = cell_in.x >>> STAGE;
      down = VECTORING ? cell_in.y[63] : !cell_in.z[63];
      if (down) begin
         step_in.x = cell_in.x - dx;
         step_in.y = cell_in.y + dy;
         step_in.z = cell_in.z - ATN;
      end else begin
         step_in.x = cell_in.x + dx;
         step_in.y = cell_in.y - dy;
         step_in.z = cell_in.z + ATN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

@@ sv/gcd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// Decides one root bit of a floored integer square root.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
   parameter int BIT = 60
) (
   input  logic              clock,
   input  logic              en,
   input  gcd_pkg::sqrt_type cell_in,
   output gcd_pkg::sqrt_type cell_out
);

   logic [121:0]      trial;
   gcd_pkg::sqrt_type step_in;
   gcd_pkg::sqrt_type step_ff;

   always_comb begin
      trial   = ({61'b0, cell_in.root} << (BIT + 1)) + (122'(1) << (2 * BIT));
      step_in = cell_in;
      if (cell_in.rem >= trial) begin
         step_in.rem  = cell_in.rem - trial;
         step_in.root = cell_in.root | (61'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

@@ sv/great_circle_distance.sv @@
// ----------------------------------------------------------------------------
// Great circle distance
// Haversine distance in mm between two points on a 6371 km sphere.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock while req_stall is low; vpipe_ff tracks
// each item to rsp_valid. The depth is set by the CORDIC cell rows (four
// sine/cosine rows and one arctangent row) and the two 61-cell square-root
// rows. The whole datapath advances together; a one-item skid behind the
// output register keeps input flowing while a result waits, and req_stall
// rises in reset and when both are full. No clearing pass after reset.
module great_circle_distance #(
   parameter int CORDIC_STAGES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_second_longitude,
   input  logic signed [30:0] req_second_latitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [34:0]        rsp_distance_mm
);

   localparam int PIPE_LAST = 86 + 2 * CORDIC_STAGES;
   localparam logic signed [63:0] INVK = signed'(gcd_pkg::inv_gain(CORDIC_STAGES));

   logic adv;
   logic [PIPE_LAST:0] vpipe_ff;

   // output register with one-item skid
   logic        rsp_valid_ff, skid_valid_ff;
   logic [34:0] rsp_data_ff, skid_data_ff;
   logic        rsp_free;

   // input capture and range folding
   logic signed [31:0] lon1_ff, lon2_ff;
   logic signed [30:0] lat1_ff, lat2_ff;
   logic signed [30:0] lat1c, lat2c;
   logic signed [33:0] dlon, dlon_r, dlon_w;
   logic signed [31:0] units_in [4];
   logic signed [31:0] units_ff [4];
   logic signed [63:0] rad_q [4];
   logic signed [63:0] rot_res [4];

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff || reset;

   always_comb begin
      lat1c = lat1_ff;
      if (lat1_ff > gcd_pkg::LAT_LIMIT) lat1c = gcd_pkg::LAT_LIMIT;
      if (lat1_ff < -gcd_pkg::LAT_LIMIT) lat1c = -gcd_pkg::LAT_LIMIT;
      lat2c = lat2_ff;
      if (lat2_ff > gcd_pkg::LAT_LIMIT) lat2c = gcd_pkg::LAT_LIMIT;
      if (lat2_ff < -gcd_pkg::LAT_LIMIT) lat2c = -gcd_pkg::LAT_LIMIT;
      dlon   = 34'(lon2_ff) - 34'(lon1_ff);
      dlon_r = dlon;
      if (dlon >= gcd_pkg::FULL_TURN) dlon_r = dlon - gcd_pkg::FULL_TURN;
      if (dlon <= -gcd_pkg::FULL_TURN) dlon_r = dlon + gcd_pkg::FULL_TURN;
      dlon_w = dlon_r;
      if (dlon_r > gcd_pkg::HALF_TURN) dlon_w = dlon_r - gcd_pkg::FULL_TURN;
      if (dlon_r < -gcd_pkg::HALF_TURN) dlon_w = dlon_r + gcd_pkg::FULL_TURN;
      units_in[0] = 32'(lat2c) - 32'(lat1c);
      units_in[1] = dlon_w[31:0];
      units_in[2] = 32'(lat1c) <<< 1;
      units_in[3] = 32'(lat2c) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff <= '0;
      end else if (adv) begin
         vpipe_ff <= {vpipe_ff[PIPE_LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lon1_ff  <= req_first_longitude;
         lat1_ff  <= req_first_latitude;
         lon2_ff  <= req_second_longitude;
         lat2_ff  <= req_second_latitude;
         units_ff <= units_in;
      end
   end

   // lanes: 0 sin(dlat/2), 1 sin(dlon/2), 2 cos(lat1), 3 cos(lat2)
   for (genvar lane = 0; lane < 4; lane++) begin : g_lane
      gcd_pkg::cordic_type rot_chain [CORDIC_STAGES+1];
      logic signed [63:0] z2, z3, p_c, p_s;
      logic signed [63:0] zd_ff [1:5];
      logic signed [63:0] xd_ff [1:6];
      logic signed [63:0] yd_ff [1:6];
      logic signed [63:0] cd_ff [3:6];
      logic signed [63:0] c_in, s_in, s_ff, z3_mag, d6, res_in;
      logic [63:0] m6_ff;
      logic neg6_ff;

      gcd_to_rad u_rad (
         .clock   (clock),
         .en      (adv),
         .units   (units_ff[lane]),
         .radians (rad_q[lane])
      );

      assign rot_chain[0] = '{x: INVK, y: 64'sd0, z: rad_q[lane]};

      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
         gcd_cordic_cell #(.STAGE(s), .VECTORING(1'b0)) u_cell (
            .clock    (clock),
            .en       (adv),
            .cell_in  (rot_chain[s]),
            .cell_out (rot_chain[s+1])
         );
      end

      gcd_mul u_zz (.clock(clock), .en(adv), .mul_a(rot_chain[CORDIC_STAGES].z),
         .mul_b(rot_chain[CORDIC_STAGES].z), .prod_q60(z2), .prod_full());
      gcd_mul u_zzz (.clock(clock), .en(adv), .mul_a(z2), .mul_b(zd_ff[2]),
         .prod_q60(z3), .prod_full());

      always_comb begin
         c_in   = signed'(gcd_pkg::QONE) - (z2 >>> 1);
         z3_mag = z3[63] ? -z3 : z3;
         d6     = signed'({34'b0, m6_ff[63:34]});
         s_in   = neg6_ff ? zd_ff[5] + d6 : zd_ff[5] - d6;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zd_ff[1] <= rot_chain[CORDIC_STAGES].z;
            xd_ff[1] <= rot_chain[CORDIC_STAGES].x;
            yd_ff[1] <= rot_chain[CORDIC_STAGES].y;
            for (int j = 2; j <= 5; j++) zd_ff[j] <= zd_ff[j-1];
            for (int j = 2; j <= 6; j++) begin
               xd_ff[j] <= xd_ff[j-1];
               yd_ff[j] <= yd_ff[j-1];
            end
            cd_ff[3] <= c_in;
            for (int j = 4; j <= 6; j++) cd_ff[j] <= cd_ff[j-1];
            m6_ff   <= {32'b0, z3_mag[31:0]} * {32'b0, gcd_pkg::DIV6_MAGIC};
            neg6_ff <= z3[63];
            s_ff    <= s_in;
         end
      end

      if (lane < 2) begin : g_sin
         gcd_mul u_pc (.clock(clock), .en(adv), .mul_a(yd_ff[6]), .mul_b(cd_ff[6]),
            .prod_q60(p_c), .prod_full());
         gcd_mul u_ps (.clock(clock), .en(adv), .mul_a(xd_ff[6]), .mul_b(s_ff),
            .prod_q60(p_s), .prod_full());
         assign res_in = p_c + p_s;
      end else begin : g_cos
         gcd_mul u_pc (.clock(clock), .en(adv), .mul_a(xd_ff[6]), .mul_b(cd_ff[6]),
            .prod_q60(p_c), .prod_full());
         gcd_mul u_ps (.clock(clock), .en(adv), .mul_a(yd_ff[6]), .mul_b(s_ff),
            .prod_q60(p_s), .prod_full());
         assign res_in = p_c - p_s;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rot_res[lane] <= res_in;
         end
      end
   end

   // haversine term
   logic [63:0]  ua_in, ub_in, uc1_in, uc2_in;
   logic [63:0]  ua_ff, ub_ff, uc1_ff, uc2_ff;
   logic signed [63:0] p_q60, q_q60;
   logic [127:0] aa_full, pq_full, aa1_ff, aa2_ff;
   logic [121:0] h_sum, h_in, hc_in;
   gcd_pkg::sqrt_type sq_s [gcd_pkg::SQRT_BITS+1];
   gcd_pkg::sqrt_type sq_c [gcd_pkg::SQRT_BITS+1];
   gcd_pkg::sqrt_type hs_ff, hc_ff;

   function automatic logic [63:0] unit_abs(logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      return (m > gcd_pkg::QONE) ? gcd_pkg::QONE : m;
   endfunction

   function automatic logic [63:0] unit_pos(logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'd0 : 64'(v);
      return (m > gcd_pkg::QONE) ? gcd_pkg::QONE : m;
   endfunction

   always_comb begin
      ua_in  = unit_abs(rot_res[0]);
      ub_in  = unit_abs(rot_res[1]);
      uc1_in = unit_pos(rot_res[2]);
      uc2_in = unit_pos(rot_res[3]);
      h_sum  = aa2_ff[121:0] + pq_full[121:0];
      h_in   = (h_sum > gcd_pkg::H_ONE) ? gcd_pkg::H_ONE : h_sum;
      hc_in  = gcd_pkg::H_ONE - h_in;
   end

   gcd_mul u_p (.clock(clock), .en(adv), .mul_a(signed'(uc1_ff)), .mul_b(signed'(ub_ff)),
      .prod_q60(p_q60), .prod_full());
   gcd_mul u_q (.clock(clock), .en(adv), .mul_a(signed'(uc2_ff)), .mul_b(signed'(ub_ff)),
      .prod_q60(q_q60), .prod_full());
   gcd_mul u_aa (.clock(clock), .en(adv), .mul_a(signed'(ua_ff)), .mul_b(signed'(ua_ff)),
      .prod_q60(), .prod_full(aa_full));
   gcd_mul u_pq (.clock(clock), .en(adv), .mul_a(p_q60), .mul_b(q_q60),
      .prod_q60(), .prod_full(pq_full));

   always_ff @(posedge clock) begin
      if (adv) begin
         ua_ff  <= ua_in;
         ub_ff  <= ub_in;
         uc1_ff <= uc1_in;
         uc2_ff <= uc2_in;
         aa1_ff <= aa_full;
         aa2_ff <= aa1_ff;
         hs_ff  <= '{rem: h_in, root: '0};
         hc_ff  <= '{rem: hc_in, root: '0};
      end
   end

   assign sq_s[0] = hs_ff;
   assign sq_c[0] = hc_ff;

   for (genvar b = 0; b < gcd_pkg::SQRT_BITS; b++) begin : g_sqrt
      gcd_sqrt_cell #(.BIT(gcd_pkg::SQRT_BITS - 1 - b)) u_s (
         .clock (clock), .en (adv), .cell_in (sq_s[b]), .cell_out (sq_s[b+1]));
      gcd_sqrt_cell #(.BIT(gcd_pkg::SQRT_BITS - 1 - b)) u_c (
         .clock (clock), .en (adv), .cell_in (sq_c[b]), .cell_out (sq_c[b+1]));
   end

   // arcsine as atan2(sqrt(h), sqrt(1-h))
   gcd_pkg::cordic_type vec_chain [CORDIC_STAGES+1];

   assign vec_chain[0] = '{
      x: signed'({3'b0, sq_c[gcd_pkg::SQRT_BITS].root}),
      y: signed'({3'b0, sq_s[gcd_pkg::SQRT_BITS].root}),
      z: 64'sd0
   };

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
      gcd_cordic_cell #(.STAGE(s), .VECTORING(1'b1)) u_cell (
         .clock    (clock),
         .en       (adv),
         .cell_in  (vec_chain[s]),
         .cell_out (vec_chain[s+1])
      );
   end

   logic signed [63:0] yk_q60, z1_ff, z2_ff, angle_sum, angle_ff;
   logic [127:0] dist_full, dist_rnd;
   logic [63:0]  dist_q;
   logic [34:0]  dist_in;

   gcd_mul u_yk (.clock(clock), .en(adv), .mul_a(vec_chain[CORDIC_STAGES].y),
      .mul_b(INVK), .prod_q60(yk_q60), .prod_full());
   gcd_mul u_dist (.clock(clock), .en(adv), .mul_a(angle_ff),
      .mul_b(signed'(gcd_pkg::DIAMETER_MM)), .prod_q60(), .prod_full(dist_full));

   always_comb begin
      angle_sum = z2_ff + yk_q60;
      dist_rnd  = dist_full + (128'(1) << 59);
      dist_q    = dist_rnd[123:60];
      dist_in   = (dist_q > gcd_pkg::HALF_CIRC_MM) ? gcd_pkg::HALF_CIRC_MM[34:0]
                                                    : dist_q[34:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z1_ff    <= vec_chain[CORDIC_STAGES].z;
         z2_ff    <= z1_ff;
         angle_ff <= angle_sum[63] ? 64'sd0 : angle_sum;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_free) begin
         rsp_valid_ff <= vpipe_ff[PIPE_LAST];
      end else if (vpipe_ff[PIPE_LAST]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (rsp_free) begin
         rsp_data_ff <= dist_in;
      end else begin
         skid_data_ff <= dist_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_mm = rsp_data_ff;

endmodule

@@ sv/gcd_checker.sv @@
// ----------------------------------------------------------------------------
// Great circle distance checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "great_circle_distance_assert.svh"

module gcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [34:0] rsp_distance_mm
);

   `GCD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp_valid after reset")
   `GCD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_mm), "stalled item changed")
   `GCD_ASSERT(a_dist_range, rsp_valid |-> rsp_distance_mm <= gcd_pkg::HALF_CIRC_MM[34:0], "distance above half circumference")
   `GCD_ASSERT(a_stall_cause, req_stall |-> rsp_valid, "input stalled with no item waiting")

endmodule

bind great_circle_distance gcd_checker u_checker (.*);
